/* rtl/core/qpt_pkg.sv */
// ----------------------------------------------------------------------------
// qpt_pkg
// Widths, word types and constants shared by the quaternion point transform.
// ----------------------------------------------------------------------------
package qpt_pkg;

  localparam int COORD_W         = 32;            // Q23.8 coordinate
  localparam int QUAT_W          = 16;            // Q1.14 quaternion part
  localparam int SQ_W            = 2 * QUAT_W - 1; // one squared part
  localparam int NORM_W          = SQ_W + 2;      // sum of four squares
  localparam int ROOT_W          = 30;            // integer square root
  localparam int RAD_W           = 2 * ROOT_W;    // radicand and root scratch
  localparam int NORM_FRAC_SHIFT = 28;            // radicand = norm * 2^28
  localparam int INV_W           = 34;            // reciprocal quotient
  localparam int DVD_W           = 2 * ROOT_W + 1; // reciprocal dividend
  localparam int QN_W            = 26;            // normalized part, 2^-24
  localparam int QN_SHIFT        = 22;
  localparam int CROSS_W         = QN_W + COORD_W;
  localparam int DIFF_W          = CROSS_W + 1;
  localparam int T_SHIFT         = 19;
  localparam int T_W             = 40;            // 2 (v x p), 2^-12
  localparam int T_LO_W          = 16;            // low slice of t per product
  localparam int TERM_W          = 64;
  localparam int W_SHIFT         = 28;
  localparam int W_W             = TERM_W - W_SHIFT;
  localparam int SUM_W           = W_W + 2;

  localparam logic [NORM_W-1:0] NORM_LOW  = NORM_W'(64'd1 << 26);
  localparam logic [NORM_W-1:0] NORM_HIGH = NORM_W'(64'd1 << 30);

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;
  localparam int QUAT_S = 3;   // scalar part

  // For axis i the cross product uses axes A and B: c_i = a_A * b_B - a_B * b_A.
  localparam int AXIS_A [3] = '{AXIS_Y, AXIS_Z, AXIS_X};
  localparam int AXIS_B [3] = '{AXIS_Z, AXIS_X, AXIS_Y};

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;

  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    coord_t [2:0] pos;
    coord_t [2:0] loc;
    quat_t  [3:0] quat;
  } qpt_item_t;

  typedef struct packed {
    logic              ok;
    logic [ROOT_W-1:0] root;
    qpt_item_t         item;
  } qpt_root_t;

  typedef struct packed {
    logic             ok;
    logic [INV_W-1:0] inv;
    qpt_item_t        item;
  } qpt_inv_t;

  typedef struct packed {
    coord_t [2:0] world;
    logic         point_valid;
  } qpt_result_t;

endpackage

/* rtl/core/qpt_if.sv */
// ----------------------------------------------------------------------------
// qpt_if
// Valid/ready channels for the input point word and the world point word.
// ----------------------------------------------------------------------------
interface qpt_in_if import qpt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  quat_t  quat_x;
  quat_t  quat_y;
  quat_t  quat_z;
  quat_t  quat_w;
  coord_t local_x;
  coord_t local_y;
  coord_t local_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
           local_x, local_y, local_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
           local_x, local_y, local_z,
    output ready
  );
endinterface

interface qpt_out_if import qpt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t world_x;
  coord_t world_y;
  coord_t world_z;
  logic   point_valid;

  modport source (
    output valid, world_x, world_y, world_z, point_valid,
    input  ready
  );
  modport sink (
    input  valid, world_x, world_y, world_z, point_valid,
    output ready
  );
endinterface

/* rtl/core/quaternion_point_transform.sv */
// ----------------------------------------------------------------------------
// quaternion_point_transform
// Normalize a bone quaternion, rotate a local point and add the bone position.
// ----------------------------------------------------------------------------
// The block takes one point word per clock while the skid register is empty
// and returns one world point word per input word, in order. The pipeline is
// made of two norm stages, the square root (a load stage and 30 stages, one
// root bit each) and the reciprocal divider (a load stage and 34 stages, one
// quotient bit each), followed by 11 rotation stages and the output register.
// A quaternion whose squared norm lies outside [0.25, 4.0] gives a zero point
// with point_valid low; a coordinate that leaves the 32-bit range is clamped
// and also clears point_valid. A one-word skid register behind the output
// register lets the pipeline keep moving while a result waits; ready drops
// only while that skid register is full.
module quaternion_point_transform import qpt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  qpt_in_if.sink           point_in,
  qpt_out_if.source        point_out
);

  logic        advance;
  logic        out_free;
  qpt_item_t   in_item;
  logic        ns_valid;
  qpt_root_t   ns_data;
  logic        rc_valid;
  qpt_inv_t    rc_data;
  logic        tail_valid;
  qpt_result_t tail_res;
  logic        out_valid;
  qpt_result_t out_res;
  logic        skid_valid;
  qpt_result_t skid_res;

  always_comb begin
    in_item.pos[AXIS_X]  = point_in.pos_x;
    in_item.pos[AXIS_Y]  = point_in.pos_y;
    in_item.pos[AXIS_Z]  = point_in.pos_z;
    in_item.quat[AXIS_X] = point_in.quat_x;
    in_item.quat[AXIS_Y] = point_in.quat_y;
    in_item.quat[AXIS_Z] = point_in.quat_z;
    in_item.quat[QUAT_S] = point_in.quat_w;
    in_item.loc[AXIS_X]  = point_in.local_x;
    in_item.loc[AXIS_Y]  = point_in.local_y;
    in_item.loc[AXIS_Z]  = point_in.local_z;
  end

  // The whole pipeline moves whenever the skid register is empty.
  assign advance        = !skid_valid;
  assign out_free       = !out_valid || point_out.ready;
  assign point_in.ready = advance;

  qpt_norm_sqrt u_norm_sqrt (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (point_in.valid),
    .in_item   (in_item),
    .out_valid (ns_valid),
    .out_data  (ns_data)
  );

  qpt_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (ns_valid),
    .in_data   (ns_data),
    .out_valid (rc_valid),
    .out_data  (rc_data)
  );

  qpt_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (rc_valid),
    .in_data   (rc_data),
    .out_valid (tail_valid),
    .out_res   (tail_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        // drain the skid word first
        out_valid  <= 1'b1;
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= tail_valid;
        out_res   <= tail_res;
      end
    end else if (advance && tail_valid) begin
      // hold the word leaving the pipeline while the output is stalled
      skid_valid <= 1'b1;
      skid_res   <= tail_res;
    end
  end

  assign point_out.valid       = out_valid;
  assign point_out.world_x     = out_res.world[AXIS_X];
  assign point_out.world_y     = out_res.world[AXIS_Y];
  assign point_out.world_z     = out_res.world[AXIS_Z];
  assign point_out.point_valid = out_res.point_valid;

endmodule

/* rtl/core/qpt_norm_sqrt.sv */
// ----------------------------------------------------------------------------
// qpt_norm_sqrt
// Squared norm, range check and a pipelined integer square root of
// norm * 2^28, one root bit per stage.
// ----------------------------------------------------------------------------
module qpt_norm_sqrt import qpt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  logic      in_valid,
  input  qpt_item_t in_item,
  output logic      out_valid,
  output qpt_root_t out_data
);

  localparam int STEPS = ROOT_W;

  logic                sq_valid;
  qpt_item_t           sq_item;
  logic [SQ_W-1:0]     sq [4];
  logic [SQ_W-1:0]     sq_next [4];

  logic                nm_valid;
  qpt_item_t           nm_item;
  logic [NORM_W-1:0]   norm;
  logic [NORM_W-1:0]   norm_next;
  logic                ok_next;

  logic [STEPS:0]      st_valid;
  qpt_item_t           st_item [STEPS+1];
  logic                st_ok   [STEPS+1];
  logic [RAD_W-1:0]    st_rem  [STEPS+1];
  logic [RAD_W-1:0]    st_root [STEPS+1];
  logic [RAD_W-1:0]    rem_next  [STEPS];
  logic [RAD_W-1:0]    root_next [STEPS];

  always_comb begin
    logic signed [2*QUAT_W-1:0] prod;
    for (int i = 0; i < 4; i++) begin
      prod       = $signed(in_item.quat[i]) * $signed(in_item.quat[i]);
      sq_next[i] = prod[SQ_W-1:0];
    end
    norm_next = NORM_W'(sq[0]) + NORM_W'(sq[1]) + NORM_W'(sq[2]) + NORM_W'(sq[3]);
    ok_next   = (norm >= NORM_LOW) && (norm <= NORM_HIGH);
  end

  // Digit-by-digit root: try root + bit against the remainder, keep on success.
  always_comb begin
    logic [RAD_W-1:0] sbit;
    logic [RAD_W-1:0] trial;
    for (int j = 0; j < STEPS; j++) begin
      sbit  = RAD_W'(1) << (2 * (STEPS - 1 - j));
      trial = st_root[j] + sbit;
      if (st_rem[j] >= trial) begin
        rem_next[j]  = st_rem[j] - trial;
        root_next[j] = (st_root[j] >> 1) + sbit;
      end else begin
        rem_next[j]  = st_rem[j];
        root_next[j] = st_root[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      nm_valid <= 1'b0;
      st_valid <= '0;
    end else if (advance) begin
      sq_valid <= in_valid;
      nm_valid <= sq_valid;
      st_valid <= {st_valid[STEPS-1:0], nm_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sq_item <= in_item;
      for (int i = 0; i < 4; i++) begin
        sq[i] <= sq_next[i];
      end
      nm_item    <= sq_item;
      norm       <= norm_next;
      st_item[0] <= nm_item;
      st_ok[0]   <= ok_next;
      st_rem[0]  <= {norm[RAD_W-NORM_FRAC_SHIFT-1:0], {NORM_FRAC_SHIFT{1'b0}}};
      st_root[0] <= '0;
      for (int j = 0; j < STEPS; j++) begin
        st_item[j+1] <= st_item[j];
        st_ok[j+1]   <= st_ok[j];
        st_rem[j+1]  <= rem_next[j];
        st_root[j+1] <= root_next[j];
      end
    end
  end

  assign out_valid     = st_valid[STEPS];
  assign out_data.ok   = st_ok[STEPS];
  assign out_data.root = st_root[STEPS][ROOT_W-1:0];
  assign out_data.item = st_item[STEPS];

endmodule

/* rtl/core/qpt_recip.sv */
// ----------------------------------------------------------------------------
// qpt_recip
// Pipelined restoring divider: inv = floor((2^60 + floor(s/2)) / s),
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module qpt_recip import qpt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  logic      in_valid,
  input  qpt_root_t in_data,
  output logic      out_valid,
  output qpt_inv_t  out_data
);

  localparam int STEPS = INV_W;
  localparam int REM_W = ROOT_W + 1;

  logic [DVD_W-1:0]  dvd;
  logic [STEPS:0]    dv_valid;
  qpt_item_t         dv_item [STEPS+1];
  logic              dv_ok   [STEPS+1];
  logic [ROOT_W-1:0] dv_div  [STEPS+1];
  logic [REM_W-1:0]  dv_rem  [STEPS+1];
  logic [INV_W-1:0]  dv_low  [STEPS+1];
  logic [INV_W-1:0]  dv_quo  [STEPS+1];
  logic [REM_W-1:0]  rem_next [STEPS];
  logic [INV_W-1:0]  quo_next [STEPS];

  assign dvd = (DVD_W'(1) << (DVD_W - 1)) + DVD_W'(in_data.root >> 1);

  // Shift in the next dividend bit, subtract the divisor where it fits.
  always_comb begin
    logic [REM_W-1:0] shifted;
    for (int j = 0; j < STEPS; j++) begin
      shifted = {dv_rem[j][REM_W-2:0], dv_low[j][INV_W-1]};
      if (shifted >= REM_W'(dv_div[j])) begin
        rem_next[j] = shifted - REM_W'(dv_div[j]);
        quo_next[j] = {dv_quo[j][INV_W-2:0], 1'b1};
      end else begin
        rem_next[j] = shifted;
        quo_next[j] = {dv_quo[j][INV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid <= '0;
    end else if (advance) begin
      dv_valid <= {dv_valid[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dv_item[0] <= in_data.item;
      dv_ok[0]   <= in_data.ok;
      dv_div[0]  <= in_data.root;
      dv_rem[0]  <= REM_W'(dvd[DVD_W-1:INV_W]);
      dv_low[0]  <= dvd[INV_W-1:0];
      dv_quo[0]  <= '0;
      for (int j = 0; j < STEPS; j++) begin
        dv_item[j+1] <= dv_item[j];
        dv_ok[j+1]   <= dv_ok[j];
        dv_div[j+1]  <= dv_div[j];
        dv_rem[j+1]  <= rem_next[j];
        dv_low[j+1]  <= dv_low[j] << 1;
        dv_quo[j+1]  <= quo_next[j];
      end
    end
  end

  assign out_valid     = dv_valid[STEPS];
  assign out_data.ok   = dv_ok[STEPS];
  assign out_data.inv  = dv_quo[STEPS];
  assign out_data.item = dv_item[STEPS];

endmodule

/* rtl/core/qpt_rotate.sv */
// ----------------------------------------------------------------------------
// qpt_rotate
// Normalize the quaternion, rotate the point with t = 2 (v x p),
// p' = p + w t + v x t, add the position and saturate.
// ----------------------------------------------------------------------------
module qpt_rotate import qpt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        in_valid,
  input  qpt_inv_t    in_data,
  output logic        out_valid,
  output qpt_result_t out_res
);

  localparam int STAGES = 11;
  localparam int PROD_W = QUAT_W + INV_W + 1;
  localparam int TR_W   = DIFF_W + 1;
  localparam int HI_W   = QN_W + T_W - T_LO_W;
  localparam int LO_W   = QN_W + T_LO_W + 1;

  localparam logic signed [PROD_W-1:0] QN_HALF = PROD_W'(1) << (QN_SHIFT - 1);
  localparam logic signed [TR_W-1:0]   T_HALF  = TR_W'(1) << (T_SHIFT - 1);
  localparam logic signed [TERM_W-1:0] W_HALF  = TERM_W'(1) << (W_SHIFT - 1);
  localparam logic signed [SUM_W-1:0]  WORLD_MAX = SUM_W'(COORD_MAX);
  localparam logic signed [SUM_W-1:0]  WORLD_MIN = SUM_W'(COORD_MIN);

  logic [STAGES-1:0] vld;

  // normalize product
  qpt_item_t                 nm_item;
  logic                      nm_ok;
  logic signed [PROD_W-1:0]  nm_prod [4];
  logic signed [PROD_W-1:0]  nm_prod_next [4];
  // normalized parts
  qpt_item_t                 qn_item;
  logic                      qn_ok;
  logic signed [QN_W-1:0]    qn_q [4];
  logic signed [QN_W-1:0]    qn_q_next [4];
  // cross products
  qpt_item_t                 cp_item;
  logic                      cp_ok;
  logic signed [QN_W-1:0]    cp_q [4];
  logic signed [CROSS_W-1:0] cp_ab [3];
  logic signed [CROSS_W-1:0] cp_ba [3];
  logic signed [CROSS_W-1:0] cp_ab_next [3];
  logic signed [CROSS_W-1:0] cp_ba_next [3];
  // cross difference
  qpt_item_t                 cd_item;
  logic                      cd_ok;
  logic signed [QN_W-1:0]    cd_q [4];
  logic signed [DIFF_W-1:0]  cd_c [3];
  logic signed [DIFF_W-1:0]  cd_c_next [3];
  // t vector
  qpt_item_t                 tv_item;
  logic                      tv_ok;
  logic signed [QN_W-1:0]    tv_q [4];
  logic signed [T_W-1:0]     tv_t [3];
  logic signed [T_W-1:0]     tv_t_next [3];
  // partial products
  qpt_item_t                 pp_item;
  logic                      pp_ok;
  logic signed [HI_W-1:0]    pp_hi [3][3];
  logic signed [LO_W-1:0]    pp_lo [3][3];
  logic signed [HI_W-1:0]    pp_hi_next [3][3];
  logic signed [LO_W-1:0]    pp_lo_next [3][3];
  // full terms
  qpt_item_t                 tm_item;
  logic                      tm_ok;
  logic signed [TERM_W-1:0]  tm_term [3][3];
  logic signed [TERM_W-1:0]  tm_term_next [3][3];
  // partial sums
  qpt_item_t                 sa_item;
  logic                      sa_ok;
  logic signed [TERM_W-1:0]  sa_ab [3];
  logic signed [TERM_W-1:0]  sa_c [3];
  // rotation offset
  qpt_item_t                 wv_item;
  logic                      wv_ok;
  logic signed [W_W-1:0]     wv_w [3];
  logic signed [W_W-1:0]     wv_w_next [3];
  // world sum
  logic                      ws_ok;
  logic signed [SUM_W-1:0]   ws_sum [3];
  logic signed [SUM_W-1:0]   ws_sum_next [3];
  // result
  qpt_result_t               res;
  qpt_result_t               res_next;

  always_comb begin
    logic signed [PROD_W-1:0] qtmp;
    logic signed [TR_W-1:0]   ttmp;
    logic signed [QN_W-1:0]   qsel;
    logic signed [T_W-1:0]    tsel;
    logic signed [TERM_W-1:0] hx;
    logic signed [TERM_W-1:0] lx;
    logic signed [TERM_W-1:0] wtmp;
    logic                     sat_ok;

    for (int i = 0; i < 4; i++) begin
      nm_prod_next[i] = $signed(in_data.item.quat[i]) * $signed({1'b0, in_data.inv});
      qtmp            = nm_prod[i] + QN_HALF;
      qn_q_next[i]    = qtmp[QN_SHIFT+QN_W-1:QN_SHIFT];
    end

    for (int i = 0; i < 3; i++) begin
      cp_ab_next[i] = qn_q[AXIS_A[i]] * $signed(qn_item.loc[AXIS_B[i]]);
      cp_ba_next[i] = qn_q[AXIS_B[i]] * $signed(qn_item.loc[AXIS_A[i]]);
      cd_c_next[i]  = cp_ab[i] - cp_ba[i];
      ttmp          = cd_c[i] + T_HALF;
      tv_t_next[i]  = ttmp[T_SHIFT+T_W-1:T_SHIFT];
    end

    // Terms of axis i: w * t_i, then v_A * t_B, then v_B * t_A (subtracted).
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        case (k)
          0: begin
            qsel = tv_q[QUAT_S];
            tsel = tv_t[i];
          end
          1: begin
            qsel = tv_q[AXIS_A[i]];
            tsel = tv_t[AXIS_B[i]];
          end
          default: begin
            qsel = tv_q[AXIS_B[i]];
            tsel = tv_t[AXIS_A[i]];
          end
        endcase
        pp_hi_next[i][k]   = qsel * $signed(tsel[T_W-1:T_LO_W]);
        pp_lo_next[i][k]   = qsel * $signed({1'b0, tsel[T_LO_W-1:0]});
        hx                 = pp_hi[i][k];
        lx                 = pp_lo[i][k];
        tm_term_next[i][k] = (hx <<< T_LO_W) + lx;
      end
    end

    for (int i = 0; i < 3; i++) begin
      wtmp           = sa_ab[i] - sa_c[i] + W_HALF;
      wv_w_next[i]   = wtmp[TERM_W-1:W_SHIFT];
      ws_sum_next[i] = $signed(wv_item.pos[i]) + $signed(wv_item.loc[i]) + wv_w[i];
    end

    // Clamp each coordinate; a clamp or a rejected norm clears the flag.
    sat_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (ws_sum[i] > WORLD_MAX) begin
        res_next.world[i] = COORD_MAX;
        sat_ok            = 1'b0;
      end else if (ws_sum[i] < WORLD_MIN) begin
        res_next.world[i] = COORD_MIN;
        sat_ok            = 1'b0;
      end else begin
        res_next.world[i] = ws_sum[i][COORD_W-1:0];
      end
      if (!ws_ok) begin
        res_next.world[i] = '0;
      end
    end
    res_next.point_valid = ws_ok && sat_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      nm_item <= in_data.item;
      nm_ok   <= in_data.ok;
      qn_item <= nm_item;
      qn_ok   <= nm_ok;
      cp_item <= qn_item;
      cp_ok   <= qn_ok;
      cd_item <= cp_item;
      cd_ok   <= cp_ok;
      tv_item <= cd_item;
      tv_ok   <= cd_ok;
      pp_item <= tv_item;
      pp_ok   <= tv_ok;
      tm_item <= pp_item;
      tm_ok   <= pp_ok;
      sa_item <= tm_item;
      sa_ok   <= tm_ok;
      wv_item <= sa_item;
      wv_ok   <= sa_ok;
      ws_ok   <= wv_ok;
      res     <= res_next;
      for (int i = 0; i < 4; i++) begin
        nm_prod[i] <= nm_prod_next[i];
        qn_q[i]    <= qn_q_next[i];
        cp_q[i]    <= qn_q[i];
        cd_q[i]    <= cp_q[i];
        tv_q[i]    <= cd_q[i];
      end
      for (int i = 0; i < 3; i++) begin
        cp_ab[i]  <= cp_ab_next[i];
        cp_ba[i]  <= cp_ba_next[i];
        cd_c[i]   <= cd_c_next[i];
        tv_t[i]   <= tv_t_next[i];
        for (int k = 0; k < 3; k++) begin
          pp_hi[i][k]   <= pp_hi_next[i][k];
          pp_lo[i][k]   <= pp_lo_next[i][k];
          tm_term[i][k] <= tm_term_next[i][k];
        end
        sa_ab[i]  <= tm_term[i][0] + tm_term[i][1];
        sa_c[i]   <= tm_term[i][2];
        wv_w[i]   <= wv_w_next[i];
        ws_sum[i] <= ws_sum_next[i];
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_res   = res;

endmodule

/* rtl/core/qpt_checker.sv */
// ----------------------------------------------------------------------------
// qpt_checker
// Port-level checks of the point transform, bound to the top level.
// ----------------------------------------------------------------------------
module qpt_checker import qpt_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input coord_t world_x,
  input coord_t world_y,
  input coord_t world_z,
  input logic   point_valid
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(world_x) && $stable(world_y)
      && $stable(world_z) && $stable(point_valid))
    else $error("output word changed under stall");

  // a flagged word is either the zero point or carries a clamped coordinate
  a_flag_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |->
      (world_x == '0 && world_y == '0 && world_z == '0) ||
      world_x == COORD_MAX || world_x == COORD_MIN ||
      world_y == COORD_MAX || world_y == COORD_MIN ||
      world_z == COORD_MAX || world_z == COORD_MIN)
    else $error("point_valid low without rejection or clamp");

  // ready drops only after an output stall
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input ready dropped without output stall");

  // while ready is low a word waits at the output
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input ready low with empty output");

  // one taken word frees the skid register
  a_ready_back: assert property (@(posedge clk) disable iff (rst)
    !in_ready && out_ready |=> in_ready)
    else $error("input ready not restored after output drained");

endmodule

bind quaternion_point_transform qpt_checker u_qpt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (point_in.ready),
  .out_valid   (point_out.valid),
  .out_ready   (point_out.ready),
  .world_x     (point_out.world_x),
  .world_y     (point_out.world_y),
  .world_z     (point_out.world_z),
  .point_valid (point_out.point_valid)
);

/* tb/quaternion_point_transform_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_point_transform_tb
// Streams point words through the transform under random idling on both
// channels and checks every world point word against a bit-exact predictor.
// ----------------------------------------------------------------------------
module quaternion_point_transform_tb;
  import qpt_pkg::*;

  localparam int LATENCY   = 80;
  localparam int WDOG_MAX  = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qpt_in_if  point_in ();
  qpt_out_if point_out ();

  quaternion_point_transform dut (
    .clk       (clk),
    .rst       (rst),
    .point_in  (point_in),
    .point_out (point_out)
  );

  always #5 clk = ~clk;

  qpt_result_t expected_points[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          err_count;
  int          word_count;
  int          rejected_count;
  int          clamped_count;
  int          idle_cycles;

  initial begin
    point_in.valid   = 1'b0;
    point_in.pos_x   = '0;
    point_in.pos_y   = '0;
    point_in.pos_z   = '0;
    point_in.quat_x  = '0;
    point_in.quat_y  = '0;
    point_in.quat_z  = '0;
    point_in.quat_w  = '0;
    point_in.local_x = '0;
    point_in.local_y = '0;
    point_in.local_z = '0;
    point_out.ready  = 1'b0;
  end

  function automatic longint round_half_up(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Predict the world point word for one input word.
  function automatic qpt_result_t transform_point(qpt_item_t it);
    qpt_result_t     res;
    longint          q[4], qn[4], p[3], t[3], w[3], v;
    longint unsigned norm, s, inv;
    res = '0;
    for (int i = 0; i < 4; i++) q[i] = longint'(it.quat[i]);
    for (int i = 0; i < 3; i++) p[i] = longint'(it.loc[i]);
    norm = 0;
    for (int i = 0; i < 4; i++) norm += longint'(q[i] * q[i]);
    if (norm < (64'd1 << 26) || norm > (64'd1 << 30)) return res;
    s   = root_floor(norm << NORM_FRAC_SHIFT);
    inv = ((64'd1 << 60) + (s >> 1)) / s;
    for (int i = 0; i < 4; i++) qn[i] = round_half_up(q[i] * longint'(inv), QN_SHIFT);
    for (int i = 0; i < 3; i++)
      t[i] = round_half_up(qn[AXIS_A[i]] * p[AXIS_B[i]] - qn[AXIS_B[i]] * p[AXIS_A[i]],
                           T_SHIFT);
    for (int i = 0; i < 3; i++)
      w[i] = round_half_up(qn[QUAT_S] * t[i] + qn[AXIS_A[i]] * t[AXIS_B[i]]
                           - qn[AXIS_B[i]] * t[AXIS_A[i]], W_SHIFT);
    res.point_valid = 1'b1;
    for (int i = 0; i < 3; i++) begin
      v = longint'(it.pos[i]) + p[i] + w[i];
      if (v > longint'(COORD_MAX)) begin
        v = longint'(COORD_MAX);
        res.point_valid = 1'b0;
      end else if (v < longint'(COORD_MIN)) begin
        v = longint'(COORD_MIN);
        res.point_valid = 1'b0;
      end
      res.world[i] = coord_t'(v);
    end
    return res;
  endfunction

  task automatic send_point(qpt_item_t it);
    qpt_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      point_in.valid <= 1'b0;
      @(posedge clk);
    end
    r = transform_point(it);
    expected_points.push_back(r);
    if (!it.quat[0] && !it.quat[1] && !it.quat[2] && !it.quat[3]) rejected_count++;
    point_in.valid   <= 1'b1;
    point_in.pos_x   <= it.pos[AXIS_X];
    point_in.pos_y   <= it.pos[AXIS_Y];
    point_in.pos_z   <= it.pos[AXIS_Z];
    point_in.local_x <= it.loc[AXIS_X];
    point_in.local_y <= it.loc[AXIS_Y];
    point_in.local_z <= it.loc[AXIS_Z];
    point_in.quat_x  <= it.quat[AXIS_X];
    point_in.quat_y  <= it.quat[AXIS_Y];
    point_in.quat_z  <= it.quat[AXIS_Z];
    point_in.quat_w  <= it.quat[QUAT_S];
    @(posedge clk);
    while (!point_in.ready) @(posedge clk);
  endtask

  // Receiver: toggle ready at random and check each word taken.
  always @(posedge clk) begin
    qpt_result_t exp_r;
    if (rst) begin
      point_out.ready <= 1'b0;
    end else begin
      if (point_out.valid && point_out.ready) begin
        word_count++;
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected world word x=%0d y=%0d z=%0d ok=%0b", $time,
                   point_out.world_x, point_out.world_y, point_out.world_z,
                   point_out.point_valid);
          err_count++;
        end else begin
          exp_r = expected_points.pop_front();
          if (!exp_r.point_valid) clamped_count++;
          if (point_out.world_x !== exp_r.world[AXIS_X] ||
              point_out.world_y !== exp_r.world[AXIS_Y] ||
              point_out.world_z !== exp_r.world[AXIS_Z] ||
              point_out.point_valid !== exp_r.point_valid) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d ok=%0b", $time,
                     exp_r.world[AXIS_X], exp_r.world[AXIS_Y], exp_r.world[AXIS_Z],
                     exp_r.point_valid);
            $display("%0t:          actual   x=%0d y=%0d z=%0d ok=%0b", $time,
                     point_out.world_x, point_out.world_y, point_out.world_z,
                     point_out.point_valid);
            err_count++;
          end
        end
      end
      point_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk) begin
    if (rst || (point_in.valid && point_in.ready) || (point_out.valid && point_out.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("FAIL quaternion_point_transform");
      $finish;
    end
  end

  function automatic qpt_item_t make_point(coord_t px, coord_t py, coord_t pz,
                                           quat_t qx, quat_t qy, quat_t qz, quat_t qw,
                                           coord_t lx, coord_t ly, coord_t lz);
    qpt_item_t it;
    it.pos[AXIS_X] = px;  it.pos[AXIS_Y] = py;  it.pos[AXIS_Z] = pz;
    it.loc[AXIS_X] = lx;  it.loc[AXIS_Y] = ly;  it.loc[AXIS_Z] = lz;
    it.quat[AXIS_X] = qx; it.quat[AXIS_Y] = qy; it.quat[AXIS_Z] = qz;
    it.quat[QUAT_S] = qw;
    return it;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 32'hFFFF)) - 32'sd32768;
      2: return $urandom_range(1) ? COORD_MAX - coord_t'($urandom_range(255))
                                  : COORD_MIN + coord_t'($urandom_range(255));
      default: return coord_t'($urandom_range(0, 32'hFFFFFF)) - 32'sd8388608;
    endcase
  endfunction

  // Quaternion with norm mostly in range, sometimes near the bounds or wild.
  function automatic void rand_quat(output quat_t q[4]);
    int sel;
    int mag;
    sel = $urandom_range(9);
    mag = (sel < 6) ? $urandom_range(4096, 32767) : (sel < 8) ? 8192 : 32767;
    for (int i = 0; i < 4; i++) q[i] = quat_t'($urandom_range(0, 2 * mag) - mag);
    if (sel == 9) for (int i = 0; i < 4; i++) q[i] = quat_t'($urandom);
    if (sel == 8) for (int i = 0; i < 4; i++) q[i] = quat_t'($urandom_range(0, 8000) - 4000);
  endfunction

  task automatic run_directed();
    // Bounds: norm exactly 0.25 and exactly 4.0 are accepted; one step out is not.
    send_point(make_point(0, 0, 0, 0, 0, 0, 16'sd8192, 32'sd256, 32'sd512, 32'sd768));
    send_point(make_point(0, 0, 0, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
                          32'sd256, -32'sd256, 32'sd1024));
    send_point(make_point(0, 0, 0, 0, 0, 16'sd1, 16'sd8191, 32'sd100, 32'sd200, 32'sd300));
    send_point(make_point(0, 0, 0, 16'sd16385, 16'sd16384, 16'sd16384, 16'sd16384,
                          32'sd5, 32'sd6, 32'sd7));
    send_point(make_point(1, 2, 3, 0, 0, 0, 0, 32'sd1, 32'sd2, 32'sd3));
    send_point(make_point(0, 0, 0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                          1, 1, 1));
    send_point(make_point(0, 0, 0, 16'sd32767, 0, 0, 0, COORD_MAX, COORD_MIN, 0));
    // 90 degrees about z, and half turns about x and y.
    send_point(make_point(32'sd1000, -32'sd1000, 0, 0, 0, 16'sd11585, 16'sd11585,
                          32'sd2560, 0, 0));
    send_point(make_point(0, 0, 0, 16'sd16384, 0, 0, 0, 32'sd300, 32'sd400, 32'sd500));
    send_point(make_point(0, 0, 0, 0, -16'sd16384, 0, 0, -32'sd300, 32'sd400, 32'sd500));
    // Saturation on each side and each axis.
    send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 16'sd16384,
                          32'sd1, 32'sd1, 32'sd1));
    send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 16'sd16384,
                          -32'sd1, -32'sd1, -32'sd1));
    send_point(make_point(COORD_MAX, COORD_MIN, 0, 0, 0, 16'sd16384, 0,
                          COORD_MIN, COORD_MAX, 0));
    send_point(make_point(COORD_MIN, COORD_MAX, COORD_MAX, -16'sd32768, 16'sd32767,
                          -16'sd32768, 16'sd32767, COORD_MAX, COORD_MIN, COORD_MIN));
    send_point(make_point(-1, -1, -1, 16'sd32767, 16'sd32767, 0, 0, -1, -1, -1));
  endtask

  task automatic run_random(int n);
    quat_t q[4];
    for (int k = 0; k < n; k++) begin
      rand_quat(q);
      send_point(make_point(rand_coord(), rand_coord(), rand_coord(),
                            q[0], q[1], q[2], q[3],
                            rand_coord(), rand_coord(), rand_coord()));
    end
  endtask

  task automatic drain_points();
    int guard;
    guard = 0;
    point_in.valid <= 1'b0;
    while (expected_points.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    err_count = 0; word_count = 0; rejected_count = 0; clamped_count = 0;
    send_idle_pct = 12;
    recv_idle_pct = 66;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random(580);
    // Hold the sender until the pipeline is empty.
    drain_points();
    send_idle_pct = 66;
    recv_idle_pct = 12;
    run_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(600);
    drain_points();
    repeat (LATENCY + 20) @(posedge clk);

    if (expected_points.size() != 0) begin
      $display("%0t: %0d world words never arrived", $time, expected_points.size());
      err_count++;
    end
    $display("Checked %0d world words (%0d flagged invalid, %0d zero quaternions)",
             word_count, clamped_count, rejected_count);
    $display("under sender/receiver idling, norm bounds, saturation and full-rate streams");
    if (err_count == 0) begin
      $display("PASS quaternion_point_transform");
    end else begin
      $display("FAIL quaternion_point_transform");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/qpt_pkg.sv
rtl/core/qpt_if.sv
rtl/core/qpt_norm_sqrt.sv
rtl/core/qpt_recip.sv
rtl/core/qpt_rotate.sv
rtl/core/quaternion_point_transform.sv
rtl/core/qpt_checker.sv
tb/quaternion_point_transform_tb.sv
